[src/scpa_pkg.sv]
package scpa_pkg;

  // Field widths of the request and response channels
  localparam int ADDR_W = 22;
  localparam int REQ_W  = 24;
  localparam int CLS_W  = 5;
  localparam int STAT_W = 2;

  // Allocator geometry
  localparam int HEADER_BYTES       = 32;
  localparam int GRAN_SHIFT         = 5;
  localparam int SIZE_W             = 24;
  localparam int NEED_W             = REQ_W + 1;
  localparam int DEF_POOL_GRANULES  = 65536;
  localparam int DEF_SIZE_CLASSES   = 18;
  localparam logic [ADDR_W-1:0] CAPACITY_RESET = ADDR_W'(2097152);

  // Configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic [0:0] REG_POOL_CAPACITY = 1'b0;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_BAD_FREE  = 2'd3
  } status_t;

  typedef struct packed {
    op_t               op;
    logic [REQ_W-1:0]  request_bytes;
    logic [ADDR_W-1:0] user_address;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] result_address;
    status_t           status;
    logic [CLS_W-1:0]  size_class;
    logic [ADDR_W-1:0] allocated_bytes;
  } result_t;

  typedef struct packed {
    logic start;
    logic commit;
  } eng_ctrl_t;

  // Block size of a class: 32 B, then 128 B doubling upwards
  function automatic logic [SIZE_W-1:0] class_size(input logic [CLS_W-1:0] cls);
    logic [SIZE_W-1:0] sz;
    if (cls == '0) begin
      sz = SIZE_W'(32);
    end else begin
      sz = SIZE_W'(64) << cls;
    end
    return sz;
  endfunction

endpackage

[src/scpa_req_if.sv]
interface scpa_req_if;
  import scpa_pkg::*;

  logic              valid;
  logic              ready;
  logic              operation;
  logic [REQ_W-1:0]  request_bytes;
  logic [ADDR_W-1:0] user_address;

  modport source (output valid, output operation, output request_bytes,
                  output user_address, input ready);
  modport sink (input valid, input operation, input request_bytes,
                input user_address, output ready);
endinterface

[src/scpa_rsp_if.sv]
interface scpa_rsp_if;
  import scpa_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] result_address;
  logic [STAT_W-1:0] status;
  logic [CLS_W-1:0]  size_class;
  logic [ADDR_W-1:0] allocated_bytes;

  modport source (output valid, output result_address, output status,
                  output size_class, output allocated_bytes, input ready);
  modport sink (input valid, input result_address, input status,
                input size_class, input allocated_bytes, output ready);
endinterface

[src/scpa_engine.sv]
module scpa_engine #(
  parameter int POOL_GRANULES = scpa_pkg::DEF_POOL_GRANULES,
  parameter int SIZE_CLASSES  = scpa_pkg::DEF_SIZE_CLASSES
) (
  input  logic                        clk,
  input  logic                        rst,
  input  scpa_pkg::eng_ctrl_t         ctrl,
  input  scpa_pkg::req_t              req,
  input  logic [scpa_pkg::ADDR_W-1:0] pool_capacity,
  output scpa_pkg::result_t           result
);
  import scpa_pkg::*;

  localparam int GW    = $clog2(POOL_GRANULES);
  localparam int CW    = (SIZE_CLASSES > 1) ? $clog2(SIZE_CLASSES) : 1;
  localparam int SUM_W = GW + GRAN_SHIFT + 1;
  localparam int CAP_W = SIZE_W;
  localparam logic [CAP_W-1:0] POOL_BYTES = CAP_W'(POOL_GRANULES * HEADER_BYTES);

  // Free-list heads: valid bits reset, indices are payload
  logic [SIZE_CLASSES-1:0] head_valid;
  logic [GW-1:0]           head_index [SIZE_CLASSES];
  logic [ADDR_W-1:0]       bump;
  logic [ADDR_W-1:0]       counter;

  // Per-granule link and class tag stores
  logic [GW:0]      link_mem [POOL_GRANULES];
  logic [CLS_W-1:0] tag_mem  [POOL_GRANULES];
  logic [GW:0]      link_rd;
  logic [CLS_W-1:0] tag_rd;

  // Request held across the execute cycle
  op_t              op_q;
  logic [CLS_W-1:0] cls_q;
  logic             too_large_q;
  logic             bad_q;
  logic [GW-1:0]    g_q;

  // Issue-cycle decode
  logic [NEED_W-1:0] need;
  logic [CLS_W-1:0]  sel_cls;
  logic              too_large;
  logic [CW-1:0]     sel_idx;
  logic [ADDR_W-1:0] free_start;
  logic              free_bad;
  logic [GW-1:0]     free_g;

  always_comb begin
    need    = NEED_W'(req.request_bytes) + NEED_W'(HEADER_BYTES);
    sel_cls = CLS_W'(SIZE_CLASSES);
    for (int i = SIZE_CLASSES - 1; i >= 0; i--) begin
      if (need <= NEED_W'(class_size(CLS_W'(i)))) begin
        sel_cls = CLS_W'(i);
      end
    end
    too_large  = (sel_cls == CLS_W'(SIZE_CLASSES));
    sel_idx    = too_large ? '0 : sel_cls[CW-1:0];
    free_start = req.user_address - ADDR_W'(HEADER_BYTES);
    free_bad   = (req.user_address < ADDR_W'(HEADER_BYTES)) ||
                 (free_start[GRAN_SHIFT-1:0] != '0) || (free_start >= bump);
    free_g     = GW'(free_start[ADDR_W-1:GRAN_SHIFT]);
  end

  // Latch the request at issue
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      op_q        <= req.op;
      cls_q       <= sel_cls;
      too_large_q <= too_large;
      bad_q       <= free_bad;
      g_q         <= free_g;
    end
  end

  // Execute-cycle update
  logic [CLS_W-1:0]  use_cls;
  logic [CW-1:0]     use_idx;
  logic [SIZE_W-1:0] sz;
  logic              hv;
  logic [GW-1:0]     hi;
  logic [CAP_W-1:0]  cap_eff;
  logic              overflow;
  logic [GW-1:0]     bump_g;
  logic [GW-1:0]     alloc_g;
  logic              head_we;
  logic              head_wvalid;
  logic [GW-1:0]     head_windex;
  logic              link_we;
  logic              tag_we;
  logic [ADDR_W-1:0] bump_next;
  logic [ADDR_W-1:0] counter_next;

  always_comb begin
    use_cls  = (op_q == OP_FREE) ? tag_rd : cls_q;
    use_idx  = use_cls[CW-1:0];
    sz       = class_size(use_cls);
    hv       = head_valid[use_idx];
    hi       = head_index[use_idx];
    cap_eff  = (CAP_W'(pool_capacity) < POOL_BYTES) ? CAP_W'(pool_capacity) : POOL_BYTES;
    overflow = ((SIZE_W + 1)'(bump) + (SIZE_W + 1)'(sz)) > (SIZE_W + 1)'(cap_eff);
    bump_g   = GW'(bump[ADDR_W-1:GRAN_SHIFT]);
    alloc_g  = hv ? hi : bump_g;

    head_we      = 1'b0;
    head_wvalid  = link_rd[GW];
    head_windex  = link_rd[GW-1:0];
    link_we      = 1'b0;
    tag_we       = 1'b0;
    bump_next    = bump;
    counter_next = counter;

    result.result_address = '0;
    result.status         = ST_OK;
    result.size_class     = '0;

    if (op_q == OP_ALLOC) begin
      if (too_large_q) begin
        result.status = ST_TOO_LARGE;
      end else if (!hv && overflow) begin
        result.status     = ST_OVERFLOW;
        result.size_class = cls_q;
      end else begin
        // pop the list head, or carve a new block from the pool
        if (hv) begin
          head_we = 1'b1;
        end else begin
          tag_we    = 1'b1;
          bump_next = bump + sz[ADDR_W-1:0];
        end
        counter_next          = counter + sz[ADDR_W-1:0];
        result.size_class     = cls_q;
        result.result_address = ADDR_W'(SUM_W'({alloc_g, {GRAN_SHIFT{1'b0}}}) +
                                        SUM_W'(HEADER_BYTES));
      end
    end else begin
      if (bad_q || (tag_rd >= CLS_W'(SIZE_CLASSES))) begin
        result.status = ST_BAD_FREE;
      end else begin
        // push the block onto its class list
        head_we           = 1'b1;
        head_wvalid       = 1'b1;
        head_windex       = g_q;
        link_we           = 1'b1;
        counter_next      = counter - sz[ADDR_W-1:0];
        result.size_class = tag_rd;
      end
    end
    result.allocated_bytes = counter_next;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= '0;
      bump       <= '0;
      counter    <= '0;
    end else if (ctrl.commit) begin
      if (head_we) begin
        head_valid[use_idx] <= head_wvalid;
      end
      bump    <= bump_next;
      counter <= counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit && head_we) begin
      head_index[use_idx] <= head_windex;
    end
  end

  // Link store: read the popped head's successor at issue, write on free
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      link_rd <= link_mem[head_index[sel_idx]];
    end
    if (ctrl.commit && link_we) begin
      link_mem[g_q] <= {hv, hi};
    end
  end

  // Class tag store: read the freed block's tag at issue, write on carve
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      tag_rd <= tag_mem[free_g];
    end
    if (ctrl.commit && tag_we) begin
      tag_mem[bump_g] <= cls_q;
    end
  end

endmodule

[src/size_class_pool_allocator_top.sv]
// Channel   Dir  Handshake         Payload
// req       in   valid / ready     operation, request_bytes, user_address
// rsp       out  valid / ready     result_address, status, size_class, allocated_bytes
// apb       in   psel / penable    paddr, pwdata -> prdata (pool_capacity at 0)
//
// Each request is first issued, reading the link and class tag memories, and then
// executed, updating the list heads and writing the memories back.
// Synchronous reset empties every free list and clears the bump pointer and
// the byte counter; the memories need no clearing. A waiting response holds
// the execute cycle; a new request is taken while a response is pending.
module size_class_pool_allocator_top #(
  parameter int POOL_GRANULES = scpa_pkg::DEF_POOL_GRANULES,
  parameter int SIZE_CLASSES  = scpa_pkg::DEF_SIZE_CLASSES
) (
  input  logic                        clk,
  input  logic                        rst,
  scpa_req_if.sink                    req,
  scpa_rsp_if.source                  rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [scpa_pkg::APB_AW-1:0] paddr,
  input  logic [scpa_pkg::APB_DW-1:0] pwdata,
  output logic [scpa_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import scpa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [ADDR_W-1:0] pool_capacity;
  eng_ctrl_t         ctrl;
  req_t              eng_req;
  result_t           eng_result;
  result_t           rsp_q;
  logic              rsp_valid;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_POOL_CAPACITY) ? APB_DW'(pool_capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_capacity <= CAPACITY_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_POOL_CAPACITY) begin
      pool_capacity <= pwdata[ADDR_W-1:0];
    end
  end

  // Issue and execute sequencing
  assign req.ready   = (state == S_IDLE);
  assign ctrl.start  = req.valid && req.ready;
  assign ctrl.commit = (state == S_EXEC) && (!rsp_valid || rsp.ready);

  assign eng_req.op            = op_t'(req.operation);
  assign eng_req.request_bytes = req.request_bytes;
  assign eng_req.user_address  = req.user_address;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (ctrl.start) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (ctrl.commit) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  scpa_engine #(
    .POOL_GRANULES (POOL_GRANULES),
    .SIZE_CLASSES  (SIZE_CLASSES)
  ) u_engine (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .req           (eng_req),
    .pool_capacity (pool_capacity),
    .result        (eng_result)
  );

  // Response register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctrl.commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      rsp_q <= eng_result;
    end
  end

  assign rsp.valid           = rsp_valid;
  assign rsp.result_address  = rsp_q.result_address;
  assign rsp.status          = rsp_q.status;
  assign rsp.size_class      = rsp_q.size_class;
  assign rsp.allocated_bytes = rsp_q.allocated_bytes;

endmodule

[dv/testbench.sv]
module testbench;
  import scpa_pkg::*;

  localparam int GRANULES    = DEF_POOL_GRANULES;
  localparam int CLASSES     = DEF_SIZE_CLASSES;
  localparam int POOL_BYTES  = GRANULES * 32;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 208;
  localparam int NOTE_LIMIT  = 40;
  localparam int QUEUE_AHEAD = 3;

  // One free-list link: valid flag plus granule index
  typedef struct packed {
    logic        live;
    logic [15:0] granule;
  } list_link_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  scpa_req_if req_ch ();
  scpa_rsp_if rsp_ch ();

  size_class_pool_allocator_top u_dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Allocator shadow state
  list_link_t        free_heads [CLASSES] = '{default: '0};
  list_link_t        chain_next [GRANULES];
  logic [CLS_W-1:0]  block_class [GRANULES];
  bit                block_tagged [GRANULES];
  int unsigned       carve_ptr = 0;
  logic [ADDR_W-1:0] bytes_live = '0;
  int unsigned       capacity_reg = 2097152;

  // Request traffic and expected responses
  req_t        pending_requests [$];
  result_t     expected_outcomes [$];
  int unsigned held_blocks [$];
  int unsigned carved_blocks [$];
  req_t        next_request;
  int          requests_queued = 0;
  int          requests_taken = 0;
  int          responses_seen = 0;
  int          mismatches = 0;
  int          cycle_count = 0;
  logic        request_fired = 1'b0;
  int          holdoff_left = 0;
  bit          holdoff_done = 1'b0;
  logic        steady_stretch;

  // Coverage tallies for the closing summary
  int grants = 0;
  int pops = 0;
  int overflows = 0;
  int oversize = 0;
  int releases = 0;
  int rejected_frees = 0;

  assign steady_stretch = (requests_taken >= 600) && (requests_taken < 800);

  always #10 clk = ~clk;

  // Hold every input at a known value, then release reset
  initial begin
    req_ch.valid = 1'b0;
    req_ch.operation = OP_ALLOC;
    req_ch.request_bytes = '0;
    req_ch.user_address = '0;
    rsp_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
  end

  function automatic int unsigned class_span(input int unsigned cls);
    return (cls == 0) ? 32 : (32'd64 << cls);
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatches++;
    if (mismatches <= NOTE_LIMIT)
      $display("ERROR %s: got 0x%0h, want 0x%0h (response %0d)", what, got, want,
               responses_seen);
  endtask

  // Work out the response of one request and advance the shadow state
  function automatic result_t allocator_outcome(input req_t item);
    result_t     res;
    int unsigned need;
    int unsigned cls;
    int unsigned span;
    int unsigned cap;
    int unsigned g;
    int unsigned start;
    res.result_address = '0;
    res.status = ST_OK;
    res.size_class = '0;
    if (item.op == OP_ALLOC) begin
      need = int'(item.request_bytes) + HEADER_BYTES;
      cls = 0;
      while (cls < CLASSES && need > class_span(cls)) cls++;
      if (cls >= CLASSES) begin
        res.status = ST_TOO_LARGE;
        oversize++;
      end else begin
        span = class_span(cls);
        res.size_class = CLS_W'(cls);
        if (free_heads[cls].live) begin
          // pop the head of the class list
          g = free_heads[cls].granule;
          free_heads[cls] = chain_next[g];
          pops++;
        end else begin
          cap = (capacity_reg < POOL_BYTES) ? capacity_reg : POOL_BYTES;
          if (carve_ptr > cap || span > cap - carve_ptr) begin
            res.status = ST_OVERFLOW;
            overflows++;
            res.allocated_bytes = bytes_live;
            return res;
          end
          // carve a fresh block from the pool
          g = carve_ptr / 32;
          block_class[g] = CLS_W'(cls);
          block_tagged[g] = 1'b1;
          carved_blocks.push_back(g * 32 + HEADER_BYTES);
          carve_ptr += span;
        end
        bytes_live = bytes_live + ADDR_W'(span);
        res.result_address = ADDR_W'(g * 32 + HEADER_BYTES);
        held_blocks.push_back(g * 32 + HEADER_BYTES);
        grants++;
      end
    end else begin
      start = int'(item.user_address) - HEADER_BYTES;
      if (item.user_address < HEADER_BYTES || start % 32 != 0 || start >= carve_ptr) begin
        res.status = ST_BAD_FREE;
        rejected_frees++;
      end else begin
        // push the block onto the list of its recorded class
        g = start / 32;
        cls = block_class[g];
        bytes_live = bytes_live - ADDR_W'(class_span(cls));
        chain_next[g] = free_heads[cls];
        free_heads[cls].live = 1'b1;
        free_heads[cls].granule = 16'(g);
        res.size_class = CLS_W'(cls);
        releases++;
      end
    end
    res.allocated_bytes = bytes_live;
    return res;
  endfunction

  // Request driver: offer the next pending request, idling at random
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || request_fired) begin
      if (pending_requests.size() != 0 &&
          (steady_stretch || $urandom_range(0, 99) >= 35)) begin
        next_request = pending_requests.pop_front();
        req_ch.valid <= 1'b1;
        req_ch.operation <= next_request.op;
        req_ch.request_bytes <= next_request.request_bytes;
        req_ch.user_address <= next_request.user_address;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Response sink: random stalls plus one long hold-off to back the block up
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (!holdoff_done && requests_taken >= 250) begin
      holdoff_left = 300;
      holdoff_done = 1'b1;
      rsp_ch.ready <= 1'b0;
    end else if (holdoff_left != 0) begin
      holdoff_left--;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= steady_stretch || ($urandom_range(0, 99) >= 35);
    end
  end

  // Monitor: check each response against the oldest expectation, then predict
  always @(posedge clk) begin : watch_channels
    result_t want;
    req_t    seen;
    if (rst) begin
      request_fired <= 1'b0;
    end else begin
      request_fired <= req_ch.valid && req_ch.ready;
      if (rsp_ch.valid && rsp_ch.ready) begin
        responses_seen++;
        if (expected_outcomes.size() == 0) begin
          note_mismatch("response with nothing expected", rsp_ch.result_address, 0);
        end else begin
          want = expected_outcomes.pop_front();
          if (rsp_ch.result_address !== want.result_address)
            note_mismatch("result_address", rsp_ch.result_address, want.result_address);
          if (rsp_ch.status !== want.status)
            note_mismatch("status", rsp_ch.status, want.status);
          if (rsp_ch.size_class !== want.size_class)
            note_mismatch("size_class", rsp_ch.size_class, want.size_class);
          if (rsp_ch.allocated_bytes !== want.allocated_bytes)
            note_mismatch("allocated_bytes", rsp_ch.allocated_bytes, want.allocated_bytes);
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        seen.op = op_t'(req_ch.operation);
        seen.request_bytes = req_ch.request_bytes;
        seen.user_address = req_ch.user_address;
        expected_outcomes.push_back(allocator_outcome(seen));
        requests_taken++;
      end
    end
  end

  // Guard against a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d responses outstanding", cycle_count,
               expected_outcomes.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic queue_item(input op_t op, input int unsigned nbytes,
                            input int unsigned uaddr);
    req_t item;
    item.op = op;
    item.request_bytes = REQ_W'(nbytes);
    item.user_address = ADDR_W'(uaddr);
    pending_requests.push_back(item);
    requests_queued++;
  endtask

  task automatic wait_until_quiet();
    while (pending_requests.size() != 0 || requests_taken != requests_queued ||
           expected_outcomes.size() != 0)
      @(negedge clk);
  endtask

  // Write the capacity register, then read it back
  task automatic write_pool_capacity(input int unsigned bytes);
    logic [APB_DW-1:0] readback;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_AW'(4 * int'(REG_POOL_CAPACITY));
    pwdata <= APB_DW'(bytes);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    capacity_reg = bytes;
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    readback = prdata;
    if (readback !== APB_DW'(bytes)) note_mismatch("pool_capacity readback", readback, bytes);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Mix of allocations, frees of held blocks, repeat frees and stray addresses
  task automatic queue_random_request();
    int unsigned roll;
    int unsigned nbytes;
    int unsigned uaddr;
    int unsigned i;
    roll = $urandom_range(0, 99);
    nbytes = $urandom_range(0, 24'hFFFFFF);
    uaddr = $urandom_range(0, 22'h3FFFFF);
    if (roll < 35 && held_blocks.size() != 0) begin
      i = $urandom_range(0, held_blocks.size() - 1);
      uaddr = held_blocks[i];
      held_blocks.delete(i);
      queue_item(OP_FREE, nbytes, uaddr);
    end else if (roll < 39 && carved_blocks.size() != 0) begin
      // may hit a block that is already listed
      uaddr = carved_blocks[$urandom_range(0, carved_blocks.size() - 1)];
      queue_item(OP_FREE, nbytes, uaddr);
    end else if (roll < 45) begin
      // steer clear of block interiors that were never tagged
      if (uaddr >= HEADER_BYTES && uaddr % 32 == 0 && uaddr - HEADER_BYTES < POOL_BYTES &&
          !block_tagged[(uaddr - HEADER_BYTES) / 32])
        uaddr |= 1;
      queue_item(OP_FREE, nbytes, uaddr);
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 50) nbytes = $urandom_range(0, 224);
      else if (roll < 80) nbytes = $urandom_range(0, 4064);
      else if (roll < 93) nbytes = $urandom_range(0, 65504);
      else if (roll < 97) nbytes = $urandom_range(0, 1048544);
      queue_item(OP_ALLOC, nbytes, uaddr);
    end
  endtask

  // Stimulus: directed corners, then random phases at several capacities
  initial begin : stimulus
    int unsigned cap;
    while (rst) @(negedge clk);
    write_pool_capacity(2097152);

    queue_item(OP_ALLOC, 0, $urandom);
    queue_item(OP_ALLOC, 1, $urandom);
    queue_item(OP_ALLOC, 96, $urandom);
    queue_item(OP_ALLOC, 97, $urandom);
    queue_item(OP_ALLOC, 24'hFFFFFF, $urandom);
    queue_item(OP_ALLOC, 8388576, $urandom);
    queue_item(OP_ALLOC, 8388577, $urandom);
    queue_item(OP_ALLOC, 1048544, $urandom);
    queue_item(OP_ALLOC, 2097120, $urandom);
    queue_item(OP_FREE, $urandom, 0);
    queue_item(OP_FREE, $urandom, 31);
    queue_item(OP_FREE, $urandom, 33);
    queue_item(OP_FREE, $urandom, 22'h3FFFFF);
    queue_item(OP_FREE, $urandom, 22'h3FFFE0);
    wait_until_quiet();

    // free exactly at the carve pointer, then recycle and double-free
    queue_item(OP_FREE, $urandom, carve_ptr + HEADER_BYTES);
    queue_item(OP_FREE, $urandom, carved_blocks[4]);
    queue_item(OP_FREE, $urandom, carved_blocks[0]);
    queue_item(OP_FREE, $urandom, carved_blocks[0]);
    queue_item(OP_ALLOC, 1048544, $urandom);
    queue_item(OP_ALLOC, 0, $urandom);
    queue_item(OP_ALLOC, 0, $urandom);
    queue_item(OP_ALLOC, 0, $urandom);
    queue_item(OP_FREE, $urandom, carved_blocks[1]);

    for (int phase = 0; phase < 6; phase++) begin
      wait_until_quiet();
      case (phase)
        0: cap = 2097151;
        1: cap = (carve_ptr + 4096 < 2097152) ? carve_ptr + 4096 : 2097152;
        2: cap = 0;
        3: cap = $urandom_range(0, 2097152);
        4: cap = 1048576;
        default: cap = 2097152;
      endcase
      write_pool_capacity(cap);
      repeat (PHASE_ITEMS) begin
        while (pending_requests.size() >= QUEUE_AHEAD) @(negedge clk);
        queue_random_request();
      end
    end

    // Drain, allow for stray responses, then conclude
    wait_until_quiet();
    repeat (20) @(posedge clk);
    $display("Ran %0d requests over 7 capacity settings in %0d cycles", requests_taken,
             cycle_count);
    $display("Grants %0d (pops %0d), frees %0d, overflows %0d, oversize %0d, bad frees %0d",
             grants, pops, releases, overflows, oversize, rejected_frees);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
src/scpa_pkg.sv
src/scpa_req_if.sv
src/scpa_rsp_if.sv
src/scpa_engine.sv
src/size_class_pool_allocator_top.sv
dv/testbench.sv
